### design/teq_pkg.sv
// Package for the timer expiry queue.
// Holds the slot record type, the sizing constants and the saturating add.
// No dependencies.
`timescale 1ns / 1ps

package teq_pkg;

  localparam int SLOTS   = 16;
  localparam int MAX_RES = 16;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RANK_W  = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int TIME_W  = 32;
  localparam int IVL_W   = 20;
  localparam int TAG_W   = 16;

  // One timer slot as it travels along the chain.
  typedef struct packed {
    logic              used;
    logic              picked;
    logic              rep;
    logic [RANK_W-1:0] rank;
    logic [TIME_W-1:0] expire;
    logic [IVL_W-1:0]  ivl;
    logic [TAG_W-1:0]  tag;
  } slot_t;

  // Time plus interval, held at the top of the time range.
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [IVL_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W + 1 - IVL_W){1'b0}}, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

### design/teq_cell.sv
// One cell of the timer ring: stores a single slot record.
// Loads its neighbor's record on every shift. Depends on teq_pkg.
`timescale 1ns / 1ps

module teq_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift,
  input  teq_pkg::slot_t d_in,
  output teq_pkg::slot_t q
);
  import teq_pkg::*;

  slot_t slot_r;

  // Only the occupancy and pick flags need a reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.used   <= 1'b0;
      slot_r.picked <= 1'b0;
    end else if (shift) begin
      slot_r <= d_in;
    end
  end

  assign q = slot_r;

endmodule

### design/timer_expiry_queue.sv
// Top level of the timer expiry queue: a ring of slot cells and its sequencer.
// Depends on teq_pkg and teq_cell.
`timescale 1ns / 1ps
//
// Usage: a transaction enters when start is high and busy is low. action 0
// adds a timer (expiry = now + interval, saturated), action 1 is a tick that
// fires every pending timer due at now, earliest expiry first, lower slot
// first on a tie, at most MAX_RES per tick.
// Results appear for one cycle each, marked by out_valid; the receiver cannot
// stall them, and the final result of a transaction has out_last set.
// The slots sit in a ring of SLOTS cells that rotates by one cell per cycle
// while a pass runs; all slot work happens at the head cell, so each pass
// visits every cell once. An add makes a scan pass and a write pass; its one
// result follows the write pass. A rejected add answers after the scan pass.
// A tick that fires n timers makes (n+1) selection passes, each followed by a
// check, one update pass, then n results back to back.
// A tick with nothing due gives its single result after one selection pass
// and the update pass. busy stays high until the last result is on the ports.
// Reset clears every slot's occupancy at once; the block is ready right away.

module timer_expiry_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_action,
  input  logic [31:0]                in_now,
  input  logic [19:0]                in_interval,
  input  logic                       in_repeat_req,
  input  logic [15:0]                in_tag,
  output logic                       out_valid,
  output logic                       out_fired_valid,
  output logic [15:0]                out_fired_tag,
  output logic                       out_earlier,
  output logic                       out_full_res,
  output logic                       out_queue_nonempty,
  output logic [31:0]                out_next_expire,
  output logic                       out_last
);
  import teq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_SCAN, S_ADD_CHK, S_ADD_WRITE, S_ADD_FIN,
    S_TICK_SEL, S_TICK_CHK, S_TICK_UPD, S_TICK_FIN, S_TICK_OUT
  } state_t;

  state_t             state_r;
  logic [IDX_W-1:0]   c_r;
  logic [TIME_W-1:0]  now_r;
  logic [TIME_W-1:0]  exp_r;
  logic [IVL_W-1:0]   ivl_r;
  logic               rep_r;
  logic [TAG_W-1:0]   tag_r;
  logic               had_r;
  logic [TIME_W-1:0]  cur_r;
  logic               free_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic               found_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [TIME_W-1:0]  best_exp_r;
  logic               mark_vld_r;
  logic [IDX_W-1:0]   mark_idx_r;
  logic [RANK_W-1:0]  mark_rank_r;
  logic [CNT_W-1:0]   n_r;
  logic [RANK_W-1:0]  k_r;
  logic               ne_r;
  logic [TIME_W-1:0]  nx_r;
  logic               pend_r;
  logic               pend_last_r;
  logic [TAG_W-1:0]   rd_tag_r;
  logic [TAG_W-1:0]   obuf [MAX_RES];

  logic               ov_r;
  logic               ofv_r;
  logic [TAG_W-1:0]   otag_r;
  logic               oear_r;
  logic               ofull_r;
  logic               one_r;
  logic [TIME_W-1:0]  onx_r;
  logic               olast_r;

  slot_t              cells_q [SLOTS];
  slot_t              h;
  slot_t              proc;
  logic               shift;
  logic               elig;
  logic               mark_hit;
  logic               pass_end;
  logic               out_last_k;
  logic [TIME_W-1:0]  add_nx;

  // Ring of cells: each takes its upper neighbor, the tail takes the head's
  // processed record.
  genvar gi;
  generate
    for (gi = 0; gi < SLOTS; gi++) begin : g_cell
      if (gi == SLOTS - 1) begin : g_tail
        teq_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift), .d_in(proc),
                         .q(cells_q[gi]));
      end else begin : g_body
        teq_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift),
                         .d_in(cells_q[gi+1]), .q(cells_q[gi]));
      end
    end
  endgenerate

  assign shift = (state_r == S_ADD_SCAN) || (state_r == S_ADD_WRITE) ||
                 (state_r == S_TICK_SEL) || (state_r == S_TICK_UPD);
  assign pass_end   = (c_r == IDX_W'(SLOTS - 1));
  assign out_last_k = ({1'b0, k_r} == CNT_W'(n_r - CNT_W'(1)));

  // Head cell processing for the current pass.
  always_comb begin
    h        = cells_q[0];
    proc     = h;
    elig     = 1'b0;
    mark_hit = mark_vld_r && (c_r == mark_idx_r);
    case (state_r)
      S_ADD_WRITE: begin
        if (c_r == free_idx_r) begin
          proc.used   = 1'b1;
          proc.picked = 1'b0;
          proc.expire = exp_r;
          proc.ivl    = ivl_r;
          proc.rep    = rep_r;
          proc.tag    = tag_r;
        end
      end
      S_TICK_SEL: begin
        if (mark_hit) begin
          proc.picked = 1'b1;
          proc.rank   = mark_rank_r;
        end
        elig = h.used && !h.picked && !mark_hit && (h.expire <= now_r) &&
               (n_r < CNT_W'(MAX_RES)) && (!found_r || (h.expire < best_exp_r));
      end
      S_TICK_UPD: begin
        if (h.picked) begin
          proc.picked = 1'b0;
          if (h.rep) begin
            proc.expire = sat_add(now_r, h.ivl);
          end else begin
            proc.used = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Earliest expiry after an accepted add.
  always_comb begin
    if (had_r && (cur_r <= exp_r)) begin
      add_nx = cur_r;
    end else begin
      add_nx = exp_r;
    end
  end

  // Result buffer in firing order, written during the update pass.
  always_ff @(posedge clk) begin
    if (state_r == S_TICK_UPD && h.picked) begin
      obuf[h.rank] <= h.tag;
    end
    if (state_r == S_TICK_OUT) begin
      rd_tag_r <= obuf[k_r];
    end
  end

  // Sequencer, datapath registers and registered result ports.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      c_r        <= '0;
      ov_r       <= 1'b0;
      pend_r     <= 1'b0;
      mark_vld_r <= 1'b0;
    end else begin
      ov_r   <= pend_r || ((state_r == S_ADD_CHK) && !free_r) ||
                (state_r == S_ADD_FIN) || ((state_r == S_TICK_FIN) && (n_r == '0));
      pend_r <= (state_r == S_TICK_OUT);
      if (shift) begin
        c_r <= pass_end ? '0 : c_r + IDX_W'(1);
      end

      // A fired timer read from the buffer into rd_tag_r is registered onto the result ports here.
      if (pend_r) begin
        ofv_r   <= 1'b1;
        otag_r  <= rd_tag_r;
        oear_r  <= 1'b0;
        ofull_r <= 1'b0;
        one_r   <= ne_r;
        onx_r   <= ne_r ? nx_r : '0;
        olast_r <= pend_last_r;
      end

      case (state_r)
        S_IDLE: begin
          if (start && !pend_r) begin
            now_r      <= in_now;
            exp_r      <= sat_add(in_now, in_interval);
            ivl_r      <= in_interval;
            rep_r      <= in_repeat_req;
            tag_r      <= in_tag;
            had_r      <= 1'b0;
            free_r     <= 1'b0;
            found_r    <= 1'b0;
            mark_vld_r <= 1'b0;
            n_r        <= '0;
            k_r        <= '0;
            ne_r       <= 1'b0;
            nx_r       <= '0;
            c_r        <= '0;
            state_r    <= in_action ? S_TICK_SEL : S_ADD_SCAN;
          end
        end
        S_ADD_SCAN: begin
          if (h.used && (!had_r || (h.expire < cur_r))) begin
            had_r <= 1'b1;
            cur_r <= h.expire;
          end
          if (!h.used && !free_r) begin
            free_r     <= 1'b1;
            free_idx_r <= c_r;
          end
          if (pass_end) begin
            state_r <= S_ADD_CHK;
          end
        end
        S_ADD_CHK: begin
          if (free_r) begin
            state_r <= S_ADD_WRITE;
          end else begin
            ofv_r   <= 1'b0;
            otag_r  <= '0;
            oear_r  <= 1'b0;
            ofull_r <= 1'b1;
            one_r   <= had_r;
            onx_r   <= had_r ? cur_r : '0;
            olast_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_ADD_WRITE: begin
          if (pass_end) begin
            state_r <= S_ADD_FIN;
          end
        end
        S_ADD_FIN: begin
          ofv_r   <= 1'b0;
          otag_r  <= '0;
          oear_r  <= !had_r || (exp_r < cur_r);
          ofull_r <= 1'b0;
          one_r   <= 1'b1;
          onx_r   <= add_nx;
          olast_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_TICK_SEL: begin
          if (elig) begin
            found_r    <= 1'b1;
            best_idx_r <= c_r;
            best_exp_r <= h.expire;
          end
          if (pass_end) begin
            state_r <= S_TICK_CHK;
          end
        end
        S_TICK_CHK: begin
          // Schedule the winner to be marked during the next pass.
          found_r <= 1'b0;
          if (found_r) begin
            mark_vld_r  <= 1'b1;
            mark_idx_r  <= best_idx_r;
            mark_rank_r <= n_r[RANK_W-1:0];
            n_r         <= n_r + CNT_W'(1);
            state_r     <= S_TICK_SEL;
          end else begin
            mark_vld_r <= 1'b0;
            state_r    <= S_TICK_UPD;
          end
        end
        S_TICK_UPD: begin
          if (proc.used && (!ne_r || (proc.expire < nx_r))) begin
            ne_r <= 1'b1;
            nx_r <= proc.expire;
          end
          if (pass_end) begin
            state_r <= S_TICK_FIN;
          end
        end
        S_TICK_FIN: begin
          if (n_r == '0) begin
            ofv_r   <= 1'b0;
            otag_r  <= '0;
            oear_r  <= 1'b0;
            ofull_r <= 1'b0;
            one_r   <= ne_r;
            onx_r   <= ne_r ? nx_r : '0;
            olast_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_TICK_OUT;
          end
        end
        S_TICK_OUT: begin
          pend_last_r <= out_last_k;
          k_r         <= k_r + RANK_W'(1);
          if (out_last_k) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The block stays busy while the last fired timer is still on its way out.
  assign busy               = (state_r != S_IDLE) || pend_r;
  assign out_valid          = ov_r;
  assign out_fired_valid    = ofv_r;
  assign out_fired_tag      = otag_r;
  assign out_earlier        = oear_r;
  assign out_full_res       = ofull_r;
  assign out_queue_nonempty = one_r;
  assign out_next_expire    = onx_r;
  assign out_last           = olast_r;

endmodule

### bench/tb_timer_expiry_queue.sv
// Testbench for the timer expiry queue: directed and random add and tick transactions.
// Checks each result against a behavioral predictor of the slot file; depends on teq_pkg.
`timescale 1ns / 1ps

module tb_timer_expiry_queue;
  import teq_pkg::*;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_TICK = 1'b1;
  localparam int   WATCHDOG = 20000;

  typedef struct packed {
    logic        action;
    logic [31:0] now;
    logic [19:0] interval;
    logic        repeat_req;
    logic [15:0] tag;
  } timer_cmd_t;

  typedef struct packed {
    logic        fired_valid;
    logic [15:0] fired_tag;
    logic        earlier;
    logic        full_res;
    logic        queue_nonempty;
    logic [31:0] next_expire;
    logic        last;
  } timer_event_t;

  logic clk, rst_n, start, busy;
  logic in_action, in_repeat_req;
  logic [31:0] in_now;
  logic [19:0] in_interval;
  logic [15:0] in_tag;
  logic out_valid, out_fired_valid, out_earlier, out_full_res, out_queue_nonempty, out_last;
  logic [15:0] out_fired_tag;
  logic [31:0] out_next_expire;

  timer_expiry_queue dut (.*);

  timer_cmd_t   pending_cmds[$];
  timer_event_t expected_events[$];
  bit           failed;
  bit           accepted;
  int           send_idle_pct;
  int           idle_cycles;

  // Predictor copy of the slot file.
  bit          pm_used[SLOTS];
  logic [31:0] pm_expire[SLOTS];
  logic [19:0] pm_ivl[SLOTS];
  bit          pm_rep[SLOTS];
  logic [15:0] pm_tag[SLOTS];

  function automatic logic [31:0] clamp_sum(logic [31:0] a, logic [19:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {13'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic bit min_expiry(output logic [31:0] best);
    bit any;
    any = 0;
    best = '0;
    for (int i = 0; i < SLOTS; i++)
      if (pm_used[i] && (!any || pm_expire[i] < best)) begin
        best = pm_expire[i];
        any = 1;
      end
    return any;
  endfunction

  // Apply one transaction to the predictor and queue its expected results.
  task automatic predict_timer_events(timer_cmd_t c);
    timer_event_t ev;
    logic [31:0] cur, nx, xp;
    bit had, ne, early, full;
    int free_slot, n, best;
    int order[MAX_RES];
    bit picked[SLOTS];
    ev = '0;
    if (c.action == ACT_ADD) begin
      free_slot = -1;
      for (int i = SLOTS - 1; i >= 0; i--) if (!pm_used[i]) free_slot = i;
      xp = clamp_sum(c.now, c.interval);
      had = min_expiry(cur);
      full = (free_slot < 0);
      early = 0;
      if (!full) begin
        early = !had || xp < cur;
        pm_used[free_slot] = 1;
        pm_expire[free_slot] = xp;
        pm_ivl[free_slot] = c.interval;
        pm_rep[free_slot] = c.repeat_req;
        pm_tag[free_slot] = c.tag;
      end
      ne = min_expiry(nx);
      ev.earlier = early;
      ev.full_res = full;
      ev.queue_nonempty = ne;
      ev.next_expire = nx;
      ev.last = 1;
      expected_events.push_back(ev);
    end else begin
      n = 0;
      for (int i = 0; i < SLOTS; i++) picked[i] = 0;
      while (n < MAX_RES) begin
        best = -1;
        for (int i = 0; i < SLOTS; i++)
          if (pm_used[i] && !picked[i] && pm_expire[i] <= c.now &&
              (best < 0 || pm_expire[i] < pm_expire[best]))
            best = i;
        if (best < 0) break;
        picked[best] = 1;
        order[n] = best;
        n = n + 1;
      end
      for (int k = 0; k < n; k++)
        if (pm_rep[order[k]]) pm_expire[order[k]] = clamp_sum(c.now, pm_ivl[order[k]]);
        else pm_used[order[k]] = 0;
      ne = min_expiry(nx);
      ev.queue_nonempty = ne;
      ev.next_expire = nx;
      if (n == 0) begin
        ev.last = 1;
        expected_events.push_back(ev);
      end
      for (int k = 0; k < n; k++) begin
        ev.fired_valid = 1;
        ev.fired_tag = pm_tag[order[k]];
        ev.last = (k == n - 1);
        expected_events.push_back(ev);
      end
    end
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: presents queued transactions at the falling edge.
  initial begin
    start = 0;
    in_action = 0;
    in_now = 0;
    in_interval = 0;
    in_repeat_req = 0;
    in_tag = 0;
  end

  // A held transaction stays on the ports until it was taken at the last rising edge.
  always @(negedge clk) begin
    if (rst_n && (!start || accepted)) begin
      if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        timer_cmd_t c;
        c = pending_cmds.pop_front();
        start <= 1;
        in_action <= c.action;
        in_now <= c.now;
        in_interval <= c.interval;
        in_repeat_req <= c.repeat_req;
        in_tag <= c.tag;
      end else begin
        start <= 0;
      end
    end
  end

  // Monitor: predicts on acceptance, checks each result.
  always @(posedge clk) begin
    if (rst_n) begin
      accepted <= start && !busy;
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (start && !busy) begin
        predict_timer_events({in_action, in_now, in_interval, in_repeat_req, in_tag});
      end
      if (out_valid) begin
        if (expected_events.size() == 0) begin
          $error("unexpected result, tag %h", out_fired_tag);
          failed = 1;
        end else begin
          timer_event_t e;
          e = expected_events.pop_front();
          if (out_fired_valid !== e.fired_valid) begin
            $error("fired_valid: expected %h actual %h", e.fired_valid, out_fired_valid);
            failed = 1;
          end
          if (out_fired_tag !== e.fired_tag) begin
            $error("fired_tag: expected %h actual %h", e.fired_tag, out_fired_tag);
            failed = 1;
          end
          if (out_earlier !== e.earlier) begin
            $error("earlier: expected %h actual %h", e.earlier, out_earlier);
            failed = 1;
          end
          if (out_full_res !== e.full_res) begin
            $error("full_res: expected %h actual %h", e.full_res, out_full_res);
            failed = 1;
          end
          if (out_queue_nonempty !== e.queue_nonempty) begin
            $error("queue_nonempty: expected %h actual %h", e.queue_nonempty,
                   out_queue_nonempty);
            failed = 1;
          end
          if (out_next_expire !== e.next_expire) begin
            $error("next_expire: expected %h actual %h", e.next_expire, out_next_expire);
            failed = 1;
          end
          if (out_last !== e.last) begin
            $error("last: expected %h actual %h", e.last, out_last);
            failed = 1;
          end
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic timer_cmd_t make_cmd(logic act, logic [31:0] now, logic [19:0] ivl,
                                          logic rep, logic [15:0] tag);
    timer_cmd_t c;
    c.action = act;
    c.now = now;
    c.interval = ivl;
    c.repeat_req = rep;
    c.tag = tag;
    return c;
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || start || busy || expected_events.size() > 0)
      @(posedge clk);
  endtask

  // Stimulus: directed corner cases, then random phases with varying idling.
  initial begin
    logic [31:0] clock_s;
    int burst;
    failed = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    rst_n = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Empty tick, zero interval repeat, saturation, extremes of the fields.
    pending_cmds.push_back(make_cmd(ACT_TICK, 32'd0, 20'd0, 1'b0, 16'd0));
    pending_cmds.push_back(make_cmd(ACT_ADD, 32'd100, 20'd0, 1'b1, 16'hFFFF));
    pending_cmds.push_back(make_cmd(ACT_ADD, 32'hFFFF_FFF0, 20'hFFFFF, 1'b0, 16'h0001));
    pending_cmds.push_back(make_cmd(ACT_ADD, 32'd50, 20'd10, 1'b0, 16'hA5A5));
    pending_cmds.push_back(make_cmd(ACT_TICK, 32'd100, 20'hFFFFF, 1'b1, 16'h5A5A));
    pending_cmds.push_back(make_cmd(ACT_TICK, 32'd101, 20'd0, 1'b0, 16'd0));
    // Fill every free slot with one expiry, let the surplus adds overflow, then tick to fire all.
    for (int i = 0; i < SLOTS + 1; i++)
      pending_cmds.push_back(make_cmd(ACT_ADD, 32'd200, 20'd5, i[0], 16'(i + 16'h100)));
    pending_cmds.push_back(make_cmd(ACT_TICK, 32'hFFFF_FFFF, 20'd0, 1'b0, 16'd0));
    wait_drained();

    // Three idling phases of random traffic around a moving time base.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 88 : 0;
      clock_s = $urandom();
      for (int j = 0; j < 130; j++) begin
        timer_cmd_t c;
        c.action = ($urandom_range(99) < 40) ? ACT_TICK : ACT_ADD;
        c.repeat_req = 1'($urandom_range(1));
        c.tag = 16'($urandom());
        burst = $urandom_range(9);
        c.interval = (burst == 0) ? 20'($urandom()) : (burst == 1) ? 20'd0 : 20'($urandom_range(40));
        if (c.action == ACT_TICK) clock_s = clamp_sum(clock_s, 20'($urandom_range(20)));
        c.now = ($urandom_range(30) == 0) ? $urandom() : clock_s;
        pending_cmds.push_back(c);
      end
      wait_drained();
    end

    repeat (4 * SLOTS + 10) @(posedge clk);
    if (!failed && expected_events.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
design/teq_pkg.sv
design/teq_cell.sv
design/timer_expiry_queue.sv
bench/tb_timer_expiry_queue.sv
